/* sv/cit_pkg.sv */
// Package with widths, request types and the material sample table of the interpolator.
package cit_pkg;

    localparam int TABLE_ENTRIES = 31;
    localparam int ROW_W  = $clog2(TABLE_ENTRIES);
    localparam int WL_W   = 20;
    localparam int IDX_W  = 19;
    localparam int DIFF_W = 17;
    localparam int DIST_W = 13;
    localparam int NUM_W  = 29;
    localparam int LANES  = 2;

    localparam int LANE_REAL = 0;
    localparam int LANE_IMAG = 1;

    localparam logic [IDX_W-1:0] REAL_MAX = 19'd327680;
    localparam logic [IDX_W-1:0] IMAG_MAX = 19'd262144;

    localparam logic [WL_W-1:0] WL_TAB [TABLE_ENTRIES] = '{
        20'd4063,  20'd5420,  20'd8126,  20'd9031,  20'd10158, 20'd11606,
        20'd13540, 20'd14772, 20'd16253, 20'd18055, 20'd20316, 20'd23213,
        20'd27086, 20'd28017, 20'd29019, 20'd30094, 20'd31254, 20'd32499,
        20'd33856, 20'd35330, 20'd36936, 20'd38692, 20'd40626, 20'd42769,
        20'd45141, 20'd47795, 20'd50784, 20'd54172, 20'd58039, 20'd62482,
        20'd63957
    };

    localparam logic [IDX_W-1:0] RE_TAB [TABLE_ENTRIES] = '{
        19'd51970,  19'd45548,  19'd52232,  19'd57147,  19'd62915,  19'd79626,
        19'd98304,  19'd93454,  19'd139657, 19'd242287, 19'd205849, 19'd209256,
        19'd288031, 19'd278921, 19'd270074, 19'd262406, 19'd255787, 19'd250216,
        19'd245432, 19'd241304, 19'd237830, 19'd234947, 19'd232587, 19'd230490,
        19'd228852, 19'd227803, 19'd227213, 19'd226492, 19'd225444, 19'd222822,
        19'd220332
    };

    localparam logic [IDX_W-1:0] IM_TAB [TABLE_ENTRIES] = '{
        19'd32375,  19'd37618,  19'd75629,  19'd85459,  19'd102629, 19'd125501,
        19'd135201, 19'd167903, 19'd229048, 19'd143262, 19'd113377, 19'd127664,
        19'd81723,  19'd63177,  19'd51511,  19'd43713,  19'd37945,  19'd33489,
        19'd29950,  19'd27263,  19'd24904,  19'd22741,  19'd20775,  19'd19202,
        19'd17695,  19'd15860,  19'd14287,  19'd13304,  19'd8520,   19'd5177,
        19'd18
    };

    typedef struct packed {
        logic [WL_W-1:0]  x;
        logic [ROW_W-1:0] seg;
    } t_loc;

    typedef struct packed {
        logic [IDX_W-1:0]  base;
        logic [DIFF_W-1:0] diff;
        logic [DIST_W-1:0] offs;
    } t_prep_lane;

    typedef struct packed {
        t_prep_lane [LANES-1:0] lane;
        logic [DIST_W-1:0]      span;
    } t_prep;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DIFF_W-1:0] quo;
        logic [IDX_W-1:0]  base;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [LANES-1:0] lane;
        logic [DIST_W-1:0]     span;
    } t_div_item;

endpackage

/* sv/cit_locate.sv */
// Segment search: parallel compares against the sample points, then a count of points passed.
module cit_locate import cit_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [WL_W-1:0] i_wavelength_um,
    output logic            o_valid,
    output t_loc            o_loc
);

    logic                     r_v1;
    logic [WL_W-1:0]          r_x1;
    logic [TABLE_ENTRIES-3:0] r_thermo;
    logic                     r_v2;
    t_loc                     r_loc;

    logic [WL_W-1:0]          n_x1;
    logic [TABLE_ENTRIES-3:0] n_thermo;

    always_comb begin
        if (i_wavelength_um < WL_TAB[0]) begin
            n_x1 = WL_TAB[0];
        end else if (i_wavelength_um > WL_TAB[TABLE_ENTRIES-1]) begin
            n_x1 = WL_TAB[TABLE_ENTRIES-1];
        end else begin
            n_x1 = i_wavelength_um;
        end
        for (int k = 0; k < TABLE_ENTRIES - 2; k++) begin
            n_thermo[k] = WL_TAB[k+1] < i_wavelength_um;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1      <= n_x1;
            r_thermo  <= n_thermo;
            r_loc.x   <= r_x1;
            r_loc.seg <= ROW_W'($countones(r_thermo));
        end
    end

    assign o_valid = r_v2;
    assign o_loc   = r_loc;

endmodule

/* sv/cit_prep.sv */
// Operand preparation: table fetch of both segment ends, distances, and the numerator product.
module cit_prep import cit_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_loc      i_loc,
    output logic      o_valid,
    output t_div_item o_item
);

    logic      r_v3;
    t_prep     r_prep;
    logic      r_v4;
    t_div_item r_item;

    t_prep     n_prep;
    t_div_item n_item;

    always_comb begin
        logic [ROW_W-1:0]  seg_b;
        logic [WL_W-1:0]   wa;
        logic [WL_W-1:0]   wb;
        logic [DIST_W-1:0] d1;
        logic [DIST_W-1:0] d2;
        logic [IDX_W-1:0]  pa;
        logic [IDX_W-1:0]  pb;
        seg_b = i_loc.seg + ROW_W'(1);
        wa = WL_TAB[i_loc.seg];
        wb = WL_TAB[seg_b];
        d1 = DIST_W'(i_loc.x - wa);
        d2 = DIST_W'(wb - i_loc.x);
        n_prep.span = DIST_W'(wb - wa);
        for (int l = 0; l < LANES; l++) begin
            if (l == LANE_REAL) begin
                pa = RE_TAB[i_loc.seg];
                pb = RE_TAB[seg_b];
            end else begin
                pa = IM_TAB[i_loc.seg];
                pb = IM_TAB[seg_b];
            end
            if (pb >= pa) begin
                n_prep.lane[l].base = pa;
                n_prep.lane[l].diff = DIFF_W'(pb - pa);
                n_prep.lane[l].offs = d1;
            end else begin
                n_prep.lane[l].base = pb;
                n_prep.lane[l].diff = DIFF_W'(pa - pb);
                n_prep.lane[l].offs = d2;
            end
        end
    end

    always_comb begin
        logic [DIFF_W+DIST_W-1:0] prod;
        n_item.span = r_prep.span;
        for (int l = 0; l < LANES; l++) begin
            prod = r_prep.lane[l].diff * r_prep.lane[l].offs;
            n_item.lane[l].rem  = NUM_W'(prod) + NUM_W'(r_prep.span >> 1);
            n_item.lane[l].quo  = '0;
            n_item.lane[l].base = r_prep.lane[l].base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
            r_item <= n_item;
        end
    end

    assign o_valid = r_v4;
    assign o_item  = r_item;

endmodule

/* sv/cit_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, for both index parts.
module cit_divider import cit_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_valid,
    output t_div_item o_item
);

    t_div_item           r_stage [DIFF_W];
    logic [DIFF_W-1:0]   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIFF_W-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < DIFF_W; s++) begin : g_stage
        localparam int BIT = DIFF_W - 1 - s;
        t_div_item        cur;
        t_div_item        n_stage;
        logic [NUM_W-1:0] shifted;

        if (s == 0) begin : g_first
            assign cur = i_item;
        end else begin : g_rest
            assign cur = r_stage[s-1];
        end

        always_comb begin
            n_stage = cur;
            shifted = NUM_W'(cur.span) << BIT;
            for (int l = 0; l < LANES; l++) begin
                if (cur.lane[l].rem >= shifted) begin
                    n_stage.lane[l].rem      = cur.lane[l].rem - shifted;
                    n_stage.lane[l].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stage[s] <= n_stage;
            end
        end
    end

    assign o_valid = r_valid[DIFF_W-1];
    assign o_item  = r_stage[DIFF_W-1];

endmodule

/* sv/complex_index_table_interpolator.sv */
// Top level of the complex refractive index table interpolator.
//
// The input channel takes one wavelength per request on i_wavelength_um, unsigned with
// 16 fraction bits. The output channel returns one result per request: o_index_real and
// o_index_imag, unsigned with 16 fraction bits and saturated to 5.0 and 4.0.
// A request is taken when i_valid is high and o_stall is low; a result is taken when
// o_valid is high and i_stall is low.
// Wavelengths below the first sample point return the first entry, those above the last
// point return the last entry, and in between the two segment ends are blended linearly
// with the quotient rounded to nearest.
// The stages are the segment search, operand fetch and the numerator product, the
// restoring divider (one quotient bit per stage) and the final add and saturation, all
// registered. Throughput is one request per cycle while o_stall is low.
// When the receiver stalls a waiting result, the whole pipeline holds and o_stall is
// raised, so nothing is lost or repeated. A synchronous reset clears all valid bits.
module complex_index_table_interpolator import cit_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WL_W-1:0]  i_wavelength_um,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_index_real,
    output logic [IDX_W-1:0] o_index_imag
);

    logic      en;
    logic      loc_valid;
    t_loc      loc;
    logic      prep_valid;
    t_div_item prep_item;
    logic      div_valid;
    t_div_item div_item;

    logic             r_valid;
    logic [IDX_W-1:0] r_real;
    logic [IDX_W-1:0] r_imag;
    logic [IDX_W-1:0] n_real;
    logic [IDX_W-1:0] n_imag;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;

    cit_locate u_locate (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_wavelength_um (i_wavelength_um),
        .o_valid         (loc_valid),
        .o_loc           (loc)
    );

    cit_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (loc_valid),
        .i_loc   (loc),
        .o_valid (prep_valid),
        .o_item  (prep_item)
    );

    cit_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_item  (prep_item),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    always_comb begin
        logic [IDX_W:0] sum_re;
        logic [IDX_W:0] sum_im;
        sum_re = {1'b0, div_item.lane[LANE_REAL].base}
               + (IDX_W + 1)'(div_item.lane[LANE_REAL].quo);
        sum_im = {1'b0, div_item.lane[LANE_IMAG].base}
               + (IDX_W + 1)'(div_item.lane[LANE_IMAG].quo);
        n_real = (sum_re > {1'b0, REAL_MAX}) ? REAL_MAX : sum_re[IDX_W-1:0];
        n_imag = (sum_im > {1'b0, IMAG_MAX}) ? IMAG_MAX : sum_im[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_real <= n_real;
            r_imag <= n_imag;
        end
    end

    assign o_valid      = r_valid;
    assign o_index_real = r_real;
    assign o_index_imag = r_imag;

endmodule

/* tb/cit_index_checker.sv */
// Checker that predicts and compares the interpolated refractive index for every request.
module cit_index_checker import cit_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_stall,
    input  logic [WL_W-1:0]  i_req_wavelength,
    input  logic             i_res_valid,
    input  logic             i_res_stall,
    input  logic [IDX_W-1:0] i_res_real,
    input  logic [IDX_W-1:0] i_res_imag,
    output int               o_mismatch_count,
    output int               o_results_due
);

    typedef struct packed {
        logic [IDX_W-1:0] re;
        logic [IDX_W-1:0] im;
    } t_index_pair;

    t_index_pair index_due [$];
    int          mismatches = 0;

    function automatic t_index_pair interp_index(input logic [WL_W-1:0] wl);
        t_index_pair r;
        logic [63:0] d1;
        logic [63:0] d2;
        logic [63:0] span;
        logic [63:0] re_v;
        logic [63:0] im_v;
        int          last;
        int          k;
        last = TABLE_ENTRIES - 1;
        re_v = 64'(RE_TAB[last]);
        im_v = 64'(IM_TAB[last]);
        if (wl < WL_TAB[0]) begin
            re_v = 64'(RE_TAB[0]);
            im_v = 64'(IM_TAB[0]);
        end else if (wl <= WL_TAB[last]) begin
            for (k = 0; k < last; k++) begin
                if (wl >= WL_TAB[k] && wl <= WL_TAB[k+1]) begin
                    d1   = 64'(wl) - 64'(WL_TAB[k]);
                    d2   = 64'(WL_TAB[k+1]) - 64'(wl);
                    span = d1 + d2;
                    re_v = (64'(RE_TAB[k]) * d2 + 64'(RE_TAB[k+1]) * d1 + span / 2) / span;
                    im_v = (64'(IM_TAB[k]) * d2 + 64'(IM_TAB[k+1]) * d1 + span / 2) / span;
                    break;
                end
            end
        end
        r.re = (re_v > 64'(REAL_MAX)) ? REAL_MAX : re_v[IDX_W-1:0];
        r.im = (im_v > 64'(IMAG_MAX)) ? IMAG_MAX : im_v[IDX_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_index_pair want;
        if (!i_rst_n) begin
            index_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (index_due.size() == 0) begin
                    $error("result with no request waiting: real %0d imag %0d",
                           i_res_real, i_res_imag);
                    mismatches++;
                end else begin
                    want = index_due.pop_front();
                    if (i_res_real !== want.re) begin
                        $error("index_real: expected %0d, actual %0d", want.re, i_res_real);
                        mismatches++;
                    end
                    if (i_res_imag !== want.im) begin
                        $error("index_imag: expected %0d, actual %0d", want.im, i_res_imag);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                index_due.push_back(interp_index(i_req_wavelength));
            end
        end
        o_mismatch_count <= mismatches;
        o_results_due    <= index_due.size();
    end

endmodule

/* tb/tb_complex_index_table_interpolator.sv */
// Testbench top that drives wavelength requests into the interpolator and gives the verdict.
module tb_complex_index_table_interpolator;
    import cit_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [WL_W-1:0]  i_wavelength_um;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [IDX_W-1:0] o_index_real;
    logic [IDX_W-1:0] o_index_imag;

    int mismatch_count;
    int results_due;
    int src_idle_pct;
    int sink_idle_pct;

    complex_index_table_interpolator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_wavelength_um (i_wavelength_um),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_index_real    (o_index_real),
        .o_index_imag    (o_index_imag)
    );

    cit_index_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_req_wavelength (i_wavelength_um),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_res_real       (o_index_real),
        .i_res_imag       (o_index_imag),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    task automatic send_wavelength(input logic [WL_W-1:0] wl);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_wavelength_um <= wl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
    endtask

    function automatic logic [WL_W-1:0] rand_wavelength();
        int sel;
        int k;
        logic [WL_W-1:0] wl;
        sel = $urandom_range(99);
        if (sel < 60) begin
            wl = WL_W'($urandom_range(WL_TAB[TABLE_ENTRIES-1], WL_TAB[0]));
        end else if (sel < 75) begin
            k  = $urandom_range(TABLE_ENTRIES - 1);
            wl = WL_W'(WL_TAB[k] + $urandom_range(2) - 1);
        end else if (sel < 85) begin
            wl = WL_W'($urandom_range(WL_TAB[0]));
        end else begin
            wl = WL_W'($urandom());
        end
        return wl;
    endfunction

    initial begin
        logic [WL_W-1:0] directed [$];
        int phase;
        int n;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_wavelength_um = '0;
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        directed = '{20'd0, 20'd1, WL_TAB[0] - 20'd1, WL_TAB[0], WL_TAB[0] + 20'd1,
                     (WL_TAB[0] + WL_TAB[1]) / 2, WL_TAB[1], WL_TAB[8] + 20'd1,
                     WL_TAB[9], WL_TAB[9] + 20'd3, WL_TAB[12],
                     (WL_TAB[28] + WL_TAB[29]) / 2, WL_TAB[29] + 20'd1,
                     WL_TAB[TABLE_ENTRIES-1] - 20'd1, WL_TAB[TABLE_ENTRIES-1],
                     WL_TAB[TABLE_ENTRIES-1] + 20'd1, 20'h10000, 20'h55555,
                     20'hAAAAA, 20'h80000, 20'hFFFFF};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[j]) send_wavelength(directed[j]);
        // Hold the sender off until every outstanding request has returned.
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 34 : (phase == 1) ? 68 : 0;
            sink_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 34 : 0;
            for (n = 0; n < 143; n++) send_wavelength(rand_wavelength());
            drain_results();
        end

        sink_idle_pct = 0;
        repeat (30) @(negedge i_clk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("tb_complex_index_table_interpolator: PASS");
        end else begin
            $display("tb_complex_index_table_interpolator: FAIL");
        end
        $finish;
    end

    initial begin
        #(400000 * 4);
        $display("tb_complex_index_table_interpolator: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/cit_pkg.sv
sv/cit_locate.sv
sv/cit_prep.sv
sv/cit_divider.sv
sv/complex_index_table_interpolator.sv
tb/cit_index_checker.sv
tb/tb_complex_index_table_interpolator.sv
